### hdl/nrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrt_pkg
// Shared types, constants and command/status bundles for the sphere table.
// ----------------------------------------------------------------------------
package nrt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = IDX_W + 1;

	localparam int POS_W = 24;
	localparam int RAD_W = 20;
	localparam int D2_W = 51;
	localparam int T_W = 25;
	localparam int ENTRY_W = 3 * POS_W + RAD_W;

	typedef enum logic [2:0] {
		FN_INSERT = 3'd0,
		FN_QUERY = 3'd1,
		FN_POP = 3'd2,
		FN_MARK = 3'd3,
		FN_BASKET = 3'd4,
		FN_EMPTY = 3'd5,
		FN_CLEAR = 3'd6,
		FN_NOP = 3'd7
	} func_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_DUP = 3'd1,
		ST_FULL = 3'd2,
		ST_EMPTY = 3'd3,
		ST_NOCUR = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SORT_RD,
		S_SORT_MV,
		S_SCAN_NEXT,
		S_FINISH,
		S_POP_RD,
		S_POP_WAIT,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic load_req;
		logic scan_init;
		logic scan_rd;
		logic scan_cmp;
		logic sort_rd;
		logic sort_mv;
		logic sort_put;
		logic scan_next;
		logic finish;
		logic pop_rd;
		logic pop_take;
		logic do_mark;
		logic do_basket;
		logic do_empty;
		logic do_clear;
		logic out_load;
	} nrt_cmd_t;

	typedef struct packed {
		func_t func;
		logic scan_done;
		logic hit;
		logic k_zero;
		logic sort_stop;
		logic list_empty;
		logic cur_valid;
	} nrt_sts_t;

endpackage

### hdl/nearest_reachable_target_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_reachable_target_table
// Sphere table with reach queries, nearest pop, pick marks and a basket.
// ----------------------------------------------------------------------------
// Requests enter on s_axis (tuser: func; tdata: pos_x, pos_y, pos_z,
// reach_or_radius); one result leaves on m_axis per request (status,
// reach_total, out_x, out_y, out_z, out_radius, basket_level, basket_full).
// One request is in work at a time. Insert and query scan every stored entry
// in turn: each entry is read and compared, and a hit runs an insertion sort
// that shifts list entries until a key compare or the list head ends it.
// Pop, mark, basket, empty, clear and no-op do not scan the table.
// The result register holds until m_axis_tready; no new request is taken
// until it is delivered, and acceptance reopens in the cycle after that.
// The basket capacity is written through cfg_we/cfg_data.
// Reset empties the table, the list, the current entry and the basket, and
// sets the capacity to 16; the entry store needs no clearing pass.
// ----------------------------------------------------------------------------
module nearest_reachable_target_table (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// func
	input logic [2:0] s_axis_tuser,
	// pos_x, pos_y, pos_z, reach_or_radius
	input logic [95:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// status, reach_total, out_x, out_y, out_z, out_radius, basket_level, basket_full
	output logic [111:0] m_axis_tdata,
	input logic cfg_we,
	input logic [7:0] cfg_data
);
	import nrt_pkg::*;

	nrt_cmd_t cmd;
	nrt_sts_t sts;
	logic [2:0] o_status;
	logic [6:0] o_total;
	logic [POS_W-1:0] o_x, o_y, o_z;
	logic [RAD_W-1:0] o_r;
	logic [7:0] o_level;
	logic o_full;

	nrt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_axis_tvalid & s_axis_tready), .in_rdy(s_axis_tready),
		.out_vld(m_axis_tvalid), .out_rdy(m_axis_tready),
		.sts(sts), .cmd(cmd)
	);

	nrt_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_func(s_axis_tuser),
		.in_x(s_axis_tdata[23:0]),
		.in_y(s_axis_tdata[47:24]),
		.in_z(s_axis_tdata[71:48]),
		.in_r(s_axis_tdata[91:72]),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.cmd(cmd), .sts(sts),
		.o_status(o_status), .o_total(o_total),
		.o_x(o_x), .o_y(o_y), .o_z(o_z), .o_r(o_r),
		.o_level(o_level), .o_full(o_full)
	);

	assign m_axis_tdata = {1'b0, o_full, o_level, o_r, o_z, o_y, o_x, o_total, o_status};

	logic unused;
	assign unused = ^s_axis_tdata[95:92];

endmodule

### hdl/nrt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrt_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module nrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### hdl/nrt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrt_ctrl
// Sequencer: scans the table, runs the insertion sort, pops and finishes.
// ----------------------------------------------------------------------------
module nrt_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	output logic in_rdy,
	output logic out_vld,
	input logic out_rdy,
	input nrt_pkg::nrt_sts_t sts,
	output nrt_pkg::nrt_cmd_t cmd
);
	import nrt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_rdy = 1'b0;
		out_vld = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_rdy = 1'b1;
				if (in_fire) begin
					cmd.load_req = 1'b1;
					state_d = S_FINISH;
					// FINISH re-dispatches once the request is latched
				end
			end
			S_FINISH: begin
				unique case (sts.func) inside
					FN_INSERT, FN_QUERY: begin
						cmd.scan_init = 1'b1;
						state_d = S_SCAN_NEXT;
					end
					FN_POP: begin
						if (sts.list_empty) begin
							cmd.out_load = 1'b1;
							state_d = S_RESULT;
						end else begin
							cmd.pop_rd = 1'b1;
							state_d = S_POP_RD;
						end
					end
					FN_MARK: begin
						cmd.do_mark = sts.cur_valid;
						cmd.out_load = 1'b1;
						state_d = S_RESULT;
					end
					FN_BASKET: begin
						cmd.do_basket = sts.cur_valid;
						state_d = S_POP_WAIT;
					end
					FN_EMPTY: begin
						cmd.do_empty = 1'b1;
						state_d = S_POP_WAIT;
					end
					FN_CLEAR: begin
						cmd.do_clear = 1'b1;
						state_d = S_POP_WAIT;
					end
					default: begin
						cmd.out_load = 1'b1;
						state_d = S_RESULT;
					end
				endcase
			end
			S_SCAN_NEXT: begin
				if (sts.scan_done) begin
					cmd.finish = 1'b1;
					state_d = S_POP_WAIT;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				state_d = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				cmd.scan_cmp = 1'b1;
				state_d = S_SORT_RD;
			end
			S_SORT_RD: begin
				if (!sts.hit) begin
					cmd.scan_next = 1'b1;
					state_d = S_SCAN_NEXT;
				end else if (sts.k_zero) begin
					cmd.sort_put = 1'b1;
					state_d = S_SCAN_NEXT;
				end else begin
					cmd.sort_rd = 1'b1;
					state_d = S_SORT_MV;
				end
			end
			S_SORT_MV: begin
				if (sts.sort_stop) begin
					cmd.sort_put = 1'b1;
					state_d = S_SCAN_NEXT;
				end else begin
					cmd.sort_mv = 1'b1;
					state_d = S_SORT_RD;
				end
			end
			S_POP_RD: begin
				state_d = S_POP_WAIT;
			end
			S_POP_WAIT: begin
				cmd.pop_take = (sts.func == FN_POP);
				cmd.out_load = 1'b1;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				out_vld = 1'b1;
				if (out_rdy) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

### hdl/nrt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrt_dp
// Datapath: sphere store, reach list with keys, distance unit, counters.
// ----------------------------------------------------------------------------
module nrt_dp (
	input logic clk,
	input logic arst_n,
	input logic [2:0] in_func,
	input logic [nrt_pkg::POS_W-1:0] in_x,
	input logic [nrt_pkg::POS_W-1:0] in_y,
	input logic [nrt_pkg::POS_W-1:0] in_z,
	input logic [nrt_pkg::RAD_W-1:0] in_r,
	input logic cfg_we,
	input logic [7:0] cfg_data,
	input nrt_pkg::nrt_cmd_t cmd,
	output nrt_pkg::nrt_sts_t sts,
	output logic [2:0] o_status,
	output logic [6:0] o_total,
	output logic [nrt_pkg::POS_W-1:0] o_x,
	output logic [nrt_pkg::POS_W-1:0] o_y,
	output logic [nrt_pkg::POS_W-1:0] o_z,
	output logic [nrt_pkg::RAD_W-1:0] o_r,
	output logic [7:0] o_level,
	output logic o_full
);
	import nrt_pkg::*;

	func_t func_q;
	logic signed [POS_W-1:0] px_q, py_q, pz_q;
	logic [RAD_W-1:0] rr_q;
	logic [7:0] cap_q, basket_q;
	logic [CNT_W-1:0] total_q, len_q, head_q, scan_q, k_q;
	logic [IDX_W-1:0] cur_q;
	logic cur_vld_q;
	logic hit_q;
	logic [D2_W-1:0] d2_q;

	// entry store
	logic e_we;
	logic [IDX_W-1:0] e_ra;
	logic [ENTRY_W-1:0] e_rd;
	nrt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_entry (
		.clk(clk), .we(e_we), .waddr(total_q[IDX_W-1:0]),
		.wdata({px_q, py_q, pz_q, rr_q}), .raddr(e_ra), .rdata(e_rd)
	);

	// picked marks, read alongside the entry during a scan
	logic p_we, p_wd, p_rd;
	logic [IDX_W-1:0] p_wa;
	nrt_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_picked (
		.clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd),
		.raddr(scan_q[IDX_W-1:0]), .rdata(p_rd)
	);

	// reach list: index plus key
	localparam int L_W = IDX_W + D2_W;
	logic l_we;
	logic [IDX_W-1:0] l_wa, l_ra;
	logic [L_W-1:0] l_wd, l_rd;
	nrt_ram #(.WIDTH(L_W), .DEPTH(TABLE_DEPTH)) u_list (
		.clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd)
	);

	logic [CNT_W-1:0] km1;
	assign km1 = k_q - CNT_W'(1);

	// pop reads entry in the cycle after the list read; keep entry read address
	logic [IDX_W-1:0] pop_idx_s1;
	logic pop_rd_s1;

	always_comb begin
		e_we = cmd.finish && (func_q == FN_INSERT) && (len_q == '0)
			&& (total_q != CNT_W'(TABLE_DEPTH));
		e_ra = pop_rd_s1 ? l_rd[L_W-1 -: IDX_W] : scan_q[IDX_W-1:0];
		p_we = e_we | cmd.do_mark;
		p_wa = e_we ? total_q[IDX_W-1:0] : cur_q;
		p_wd = cmd.do_mark;
		l_ra = cmd.pop_rd ? head_q[IDX_W-1:0] : km1[IDX_W-1:0];
		l_we = cmd.sort_mv | cmd.sort_put;
		l_wa = k_q[IDX_W-1:0];
		l_wd = cmd.sort_mv ? l_rd : {scan_q[IDX_W-1:0], d2_q};
	end

	always_ff @(posedge clk) begin
		pop_rd_s1 <= cmd.pop_rd;
		if (pop_rd_s1) pop_idx_s1 <= l_rd[L_W-1 -: IDX_W];
	end

	// distance unit: entry fields land after scan_rd
	logic signed [POS_W:0] dx, dy, dz;
	logic [2*POS_W+1:0] sx, sy, sz;
	logic [T_W-1:0] tt;
	always_comb begin
		dx = (POS_W+1)'($signed(e_rd[ENTRY_W-1 -: POS_W])) - (POS_W+1)'(px_q);
		dy = (POS_W+1)'($signed(e_rd[ENTRY_W-POS_W-1 -: POS_W])) - (POS_W+1)'(py_q);
		dz = (POS_W+1)'($signed(e_rd[RAD_W+POS_W-1 -: POS_W])) - (POS_W+1)'(pz_q);
		sx = (2*POS_W+2)'(dx * dx);
		sy = (2*POS_W+2)'(dy * dy);
		sz = (2*POS_W+2)'(dz * dz);
		tt = T_W'(rr_q) * ((func_q == FN_INSERT) ? T_W'(11) : T_W'(10))
			+ T_W'(e_rd[RAD_W-1:0]) * T_W'(10);
	end

	logic [2*POS_W+1:0] sx_s1, sy_s1, sz_s1;
	logic [2*T_W-1:0] t2_s1;
	logic [T_W-1:0] tt_s1;
	always_ff @(posedge clk) begin
		sx_s1 <= sx; sy_s1 <= sy; sz_s1 <= sz; tt_s1 <= tt;
	end
	assign t2_s1 = tt_s1 * tt_s1;

	logic [D2_W-1:0] d2_s1;
	logic [D2_W+6:0] d100_s1;
	assign d2_s1 = D2_W'(sx_s1) + D2_W'(sy_s1) + D2_W'(sz_s1);
	assign d100_s1 = {d2_s1, 6'b0} + {d2_s1, 5'b0} + {4'b0, d2_s1, 2'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 8'd16;
			basket_q <= '0;
			total_q <= '0;
			len_q <= '0;
			head_q <= '0;
			cur_q <= '0;
			cur_vld_q <= 1'b0;
			scan_q <= '0;
			k_q <= '0;
			hit_q <= 1'b0;
			func_q <= FN_NOP;
		end else begin
			if (cfg_we) cap_q <= cfg_data;
			if (cmd.load_req) func_q <= func_t'(in_func);
			if (cmd.scan_init) begin
				scan_q <= '0;
				len_q <= '0;
				head_q <= '0;
			end
			if (cmd.scan_cmp) begin
				hit_q <= !p_rd && ({7'b0, d100_s1} < {8'b0, t2_s1});
				k_q <= len_q;
			end
			if (cmd.sort_mv) k_q <= km1;
			if (cmd.sort_put) begin
				len_q <= len_q + CNT_W'(1);
				scan_q <= scan_q + CNT_W'(1);
			end
			if (cmd.scan_next) scan_q <= scan_q + CNT_W'(1);
			if (e_we) total_q <= total_q + CNT_W'(1);
			if (cmd.pop_take) begin
				head_q <= head_q + CNT_W'(1);
				cur_q <= pop_idx_s1;
				cur_vld_q <= 1'b1;
			end
			if (cmd.do_basket && basket_q != 8'hFF) basket_q <= basket_q + 8'd1;
			if (cmd.do_empty) basket_q <= '0;
			if (cmd.do_clear) begin
				total_q <= '0;
				len_q <= '0;
				head_q <= '0;
				cur_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			px_q <= in_x; py_q <= in_y; pz_q <= in_z; rr_q <= in_r;
		end
		if (cmd.scan_cmp) d2_q <= d2_s1;
	end

	always_comb begin
		sts.func = func_q;
		sts.scan_done = (scan_q >= total_q);
		sts.hit = hit_q;
		sts.k_zero = (k_q == '0);
		sts.sort_stop = (l_rd[D2_W-1:0] <= d2_q);
		sts.list_empty = (head_q >= len_q);
		sts.cur_valid = cur_vld_q;
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			o_status <= ST_OK;
			o_x <= '0; o_y <= '0; o_z <= '0; o_r <= '0;
			unique case (func_q) inside
				FN_INSERT: begin
					if (len_q != '0) o_status <= ST_DUP;
					else if (scan_q == CNT_W'(TABLE_DEPTH)) o_status <= ST_FULL;
				end
				FN_POP: begin
					if (!cmd.pop_take) o_status <= ST_EMPTY;
					else begin
						o_x <= e_rd[ENTRY_W-1 -: POS_W];
						o_y <= e_rd[ENTRY_W-POS_W-1 -: POS_W];
						o_z <= e_rd[RAD_W+POS_W-1 -: POS_W];
						o_r <= e_rd[RAD_W-1:0];
					end
				end
				FN_MARK, FN_BASKET: if (!cur_vld_q) o_status <= ST_NOCUR;
				default: ;
			endcase
		end
	end

	logic [CNT_W-1:0] head_nx;
	assign head_nx = head_q + (cmd.pop_take ? CNT_W'(1) : CNT_W'(0));
	logic [6:0] tot_d;
	always_comb begin
		if (func_q == FN_INSERT || func_q == FN_QUERY) tot_d = 7'(len_q);
		else if (func_q == FN_CLEAR) tot_d = '0;
		else tot_d = (head_nx < len_q) ? 7'(len_q - head_nx) : 7'd0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) o_total <= tot_d;
	end
	assign o_level = basket_q;
	assign o_full = (basket_q >= cap_q);

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sphere table: directed requests cover the corner
// cases, then random pick sequences run under three back-pressure patterns
// with different basket capacities; every result is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import nrt_pkg::*;

	typedef struct {
		func_t func;
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
		logic [19:0] rad;
	} sphere_req_t;

	typedef struct {
		status_t status;
		logic [6:0] total;
		logic [23:0] ox;
		logic [23:0] oy;
		logic [23:0] oz;
		logic [19:0] orad;
		logic [7:0] level;
		logic full;
	} table_rsp_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [2:0] s_axis_tuser;
	logic [95:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [111:0] m_axis_tdata;
	logic cfg_we;
	logic [7:0] cfg_data;

	nearest_reachable_target_table uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	sphere_req_t pending_reqs[$];
	table_rsp_t expected_rsps[$];
	int errors = 0;
	int reqs_sent = 0;
	int rsps_seen = 0;
	int cycles = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit req_taken = 0;

	// table model
	longint sx[TABLE_DEPTH];
	longint sy[TABLE_DEPTH];
	longint sz[TABLE_DEPTH];
	longint unsigned srad[TABLE_DEPTH];
	bit spicked[TABLE_DEPTH];
	int stored;
	int near_list[TABLE_DEPTH];
	longint unsigned near_key[TABLE_DEPTH];
	int near_len;
	int near_head;
	int cur_idx;
	bit cur_ok;
	int basket;
	int capacity;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int scan_reach(longint px, longint py, longint pz,
			longint unsigned reach10);
		int n;
		int k;
		longint dx;
		longint dy;
		longint dz;
		longint unsigned d2;
		longint unsigned t;
		n = 0;
		for (int i = 0; i < stored; i++) begin
			if (spicked[i])
				continue;
			dx = sx[i] - px;
			dy = sy[i] - py;
			dz = sz[i] - pz;
			d2 = dx * dx + dy * dy + dz * dz;
			t = reach10 + 10 * srad[i];
			if (100 * d2 >= t * t)
				continue;
			k = n;
			while (k > 0 && near_key[k - 1] > d2) begin
				near_key[k] = near_key[k - 1];
				near_list[k] = near_list[k - 1];
				k--;
			end
			near_key[k] = d2;
			near_list[k] = i;
			n++;
		end
		near_len = n;
		near_head = 0;
		return n;
	endfunction

	function automatic table_rsp_t predict_result(sphere_req_t r);
		table_rsp_t e;
		longint px;
		longint py;
		longint pz;
		bit listed;
		int idx;
		px = r.x;
		py = r.y;
		pz = r.z;
		listed = 0;
		e.status = ST_OK;
		e.ox = '0;
		e.oy = '0;
		e.oz = '0;
		e.orad = '0;
		case (r.func)
			FN_INSERT: begin
				listed = 1;
				if (scan_reach(px, py, pz, 11 * longint'(r.rad)) > 0)
					e.status = ST_DUP;
				else if (stored >= TABLE_DEPTH)
					e.status = ST_FULL;
				else begin
					sx[stored] = px;
					sy[stored] = py;
					sz[stored] = pz;
					srad[stored] = longint'(r.rad);
					spicked[stored] = 0;
					stored++;
				end
			end
			FN_QUERY: begin
				listed = 1;
				void'(scan_reach(px, py, pz, 10 * longint'(r.rad)));
			end
			FN_POP: begin
				if (near_head >= near_len)
					e.status = ST_EMPTY;
				else begin
					idx = near_list[near_head];
					near_head++;
					cur_idx = idx;
					cur_ok = 1;
					e.ox = sx[idx][23:0];
					e.oy = sy[idx][23:0];
					e.oz = sz[idx][23:0];
					e.orad = srad[idx][19:0];
				end
			end
			FN_MARK: begin
				if (!cur_ok)
					e.status = ST_NOCUR;
				else
					spicked[cur_idx] = 1;
			end
			FN_BASKET: begin
				if (!cur_ok)
					e.status = ST_NOCUR;
				else if (basket < 255)
					basket++;
			end
			FN_EMPTY: basket = 0;
			FN_CLEAR: begin
				stored = 0;
				near_len = 0;
				near_head = 0;
				cur_ok = 0;
			end
			default: ;
		endcase
		if (listed)
			e.total = near_len[6:0];
		else
			e.total = (near_head < near_len) ? 7'(near_len - near_head) : 7'd0;
		e.level = basket[7:0];
		e.full = basket >= capacity;
		return e;
	endfunction

	task automatic report(string field, longint unsigned got, longint unsigned want);
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
		errors++;
	endtask

	// request side
	always @(negedge clk) begin
		if (!s_axis_tvalid || req_taken) begin
			if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= pending_reqs[0].func;
				s_axis_tdata <= {4'b0, pending_reqs[0].rad, pending_reqs[0].z,
					pending_reqs[0].y, pending_reqs[0].x};
			end else
				s_axis_tvalid <= 1'b0;
		end
		req_taken = 0;
		m_axis_tready <= $urandom_range(0, 99) >= rx_idle_pct;
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			expected_rsps.insert(expected_rsps.size(), predict_result(pending_reqs[0]));
			pending_reqs.delete(0);
			reqs_sent++;
			req_taken = 1;
		end
	end

	// result side
	always @(posedge clk) begin
		table_rsp_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			rsps_seen++;
			if (expected_rsps.size() == 0) begin
				$display("[%0t] result with nothing outstanding", $time);
				errors++;
			end else begin
				e = expected_rsps[0];
				expected_rsps.delete(0);
				if (m_axis_tdata[2:0] !== e.status)
					report("status", m_axis_tdata[2:0], e.status);
				if (m_axis_tdata[9:3] !== e.total)
					report("reach_total", m_axis_tdata[9:3], e.total);
				if (m_axis_tdata[33:10] !== e.ox)
					report("out_x", m_axis_tdata[33:10], e.ox);
				if (m_axis_tdata[57:34] !== e.oy)
					report("out_y", m_axis_tdata[57:34], e.oy);
				if (m_axis_tdata[81:58] !== e.oz)
					report("out_z", m_axis_tdata[81:58], e.oz);
				if (m_axis_tdata[101:82] !== e.orad)
					report("out_radius", m_axis_tdata[101:82], e.orad);
				if (m_axis_tdata[109:102] !== e.level)
					report("basket_level", m_axis_tdata[109:102], e.level);
				if (m_axis_tdata[110] !== e.full)
					report("basket_full", m_axis_tdata[110], e.full);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 30000000) begin
			$display("timeout after %0d cycles, %0d requests left", cycles,
				pending_reqs.size() + expected_rsps.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic add_req(func_t f, int x, int y, int z, int rad);
		sphere_req_t r;
		r.func = f;
		r.x = 24'(x);
		r.y = 24'(y);
		r.z = 24'(z);
		r.rad = 20'(rad);
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	function automatic int near_coord();
		if ($urandom_range(0, 9) == 0)
			return int'($urandom);
		return (int'($urandom_range(0, 8)) - 4) * 32'h10000 + int'($urandom_range(0, 4095));
	endfunction

	function automatic int pick_rad();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return int'($urandom);
			default: return int'($urandom_range(0, 32'h18000));
		endcase
	endfunction

	task automatic add_random(func_t f);
		add_req(f, near_coord(), near_coord(), near_coord(), pick_rad());
	endtask

	// optional insert, query, one to three pops, then an optional pick and a basket
	task automatic add_pick_run();
		int pops;
		pops = $urandom_range(1, 3);
		if ($urandom_range(0, 2) == 0)
			add_random(FN_INSERT);
		add_random(FN_QUERY);
		repeat (pops)
			add_random(FN_POP);
		if ($urandom_range(0, 3) != 0)
			add_random(FN_MARK);
		add_random(FN_BASKET);
	endtask

	task automatic fill_random(int count);
		int f;
		repeat (count) begin
			if ($urandom_range(0, 9) < 5)
				add_pick_run();
			else begin
				f = $urandom_range(0, 99);
				if (f < 40)
					add_random(FN_INSERT);
				else if (f < 55)
					add_random(FN_QUERY);
				else if (f < 70)
					add_random(FN_POP);
				else if (f < 78)
					add_random(FN_MARK);
				else if (f < 90)
					add_random(FN_BASKET);
				else if (f < 95)
					add_random(FN_EMPTY);
				else if (f < 97)
					add_random(FN_CLEAR);
				else
					add_random(FN_NOP);
			end
		end
	endtask

	task automatic drain();
		wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_capacity(int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value[7:0];
		capacity = value & 255;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tuser = '0;
		s_axis_tdata = '0;
		m_axis_tready = 0;
		cfg_we = 0;
		cfg_data = '0;
		stored = 0;
		near_len = 0;
		near_head = 0;
		cur_idx = 0;
		cur_ok = 0;
		basket = 0;
		capacity = 16;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed corners at the reset capacity
		add_req(FN_MARK, 0, 0, 0, 0);
		add_req(FN_BASKET, 0, 0, 0, 0);
		add_req(FN_POP, 0, 0, 0, 0);
		add_req(FN_INSERT, 0, 0, 0, 32'h10000);
		add_req(FN_INSERT, 32'h8000, 0, 0, 32'h1000);
		add_req(FN_INSERT, 32'h7FFFFF, 32'h7FFFFF, 32'h7FFFFF, 32'hFFFFF);
		add_req(FN_INSERT, -32'h800000, -32'h800000, -32'h800000, 32'hFFFFF);
		add_req(FN_INSERT, 32'h30000, 0, 0, 0);
		add_req(FN_QUERY, 0, 0, 0, 0);
		add_req(FN_QUERY, 0, 0, 0, 32'hFFFFF);
		add_req(FN_POP, 0, 0, 0, 0);
		add_req(FN_MARK, 0, 0, 0, 0);
		add_req(FN_BASKET, 0, 0, 0, 0);
		add_req(FN_POP, 0, 0, 0, 0);
		add_req(FN_POP, 0, 0, 0, 0);
		add_req(FN_POP, 0, 0, 0, 0);
		add_req(FN_POP, 0, 0, 0, 0);
		add_req(FN_NOP, 32'h7FFFFF, -1, 5, 32'hFFFFF);
		add_req(FN_EMPTY, 0, 0, 0, 0);
		add_req(FN_CLEAR, 0, 0, 0, 0);
		add_req(FN_POP, 0, 0, 0, 0);
		add_req(FN_MARK, 0, 0, 0, 0);
		drain();

		write_capacity(0);
		tx_idle_pct = 24;
		rx_idle_pct = 68;
		fill_random(120);
		// fill the table with zero-radius spheres until it reports full
		add_req(FN_CLEAR, 0, 0, 0, 0);
		for (int i = 0; i < TABLE_DEPTH + 3; i++)
			add_req(FN_INSERT, i * 32'h10000, -i, 32'h1234, 0);
		add_req(FN_QUERY, 32'h200000, 0, 32'h1234, 32'h300000);
		fill_random(30);
		drain();

		write_capacity(255);
		tx_idle_pct = 68;
		rx_idle_pct = 24;
		add_req(FN_CLEAR, 0, 0, 0, 0);
		add_req(FN_INSERT, 32'h50000, 32'h50000, 0, 32'h8000);
		add_req(FN_QUERY, 32'h50000, 32'h50000, 0, 32'h8000);
		add_req(FN_POP, 0, 0, 0, 0);
		repeat (260)
			add_req(FN_BASKET, 0, 0, 0, 0);
		fill_random(100);
		drain();

		write_capacity($urandom_range(1, 254));
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		fill_random(70);
		drain();

		$display("%0d requests sent, %0d results checked, %0d mismatches",
			reqs_sent, rsps_seen, errors);
		$display("covered insert, query, pop, pick, basket, clear under three stall patterns");
		if (errors == 0 && expected_rsps.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
